FILE: hw/rtl/fqlm_pkg.sv
package fqlm_pkg;

  localparam int ID_W           = 4;
  localparam int STATUS_W       = 3;
  localparam int REQUESTERS_DEF = 16;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HANDOFF = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd4;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] requester;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     grant_id;
  } resp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/fqlm_ctrl.sv
module fqlm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fqlm_pkg::sts_t sts,
  output fqlm_pkg::cmd_t cmd
);
  import fqlm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the item until the output register can take the result
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_EXEC)
    else $error("captured item not followed by execute");

  a_no_capture_and_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

endmodule

FILE: hw/rtl/fqlm_datapath.sv
module fqlm_datapath #(
  parameter int REQUESTERS = fqlm_pkg::REQUESTERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  fqlm_pkg::req_t  in_data,
  input  logic            out_ready,
  output logic            out_valid,
  output fqlm_pkg::resp_t out_data,
  input  fqlm_pkg::cmd_t  cmd,
  output fqlm_pkg::sts_t  sts
);
  import fqlm_pkg::*;

  // ids are 4 bits wide, so no more than 16 entries are ever reachable
  localparam int DEPTH = (REQUESTERS < (1 << ID_W)) ? REQUESTERS : (1 << ID_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIDE_W = ID_W + IDX_W;
  localparam logic [WIDE_W:0] REQ_LIM = (WIDE_W + 1)'(REQUESTERS);

  req_t             req_q;
  logic             holder_valid;
  logic [IDX_W-1:0] holder_id;
  logic             tail_valid;
  logic [IDX_W-1:0] tail_id;
  logic [DEPTH-1:0] succ_valid;
  logic [IDX_W-1:0] succ_id [DEPTH];
  logic [DEPTH-1:0] waiting;

  logic [WIDE_W-1:0] wide_r;
  logic [WIDE_W-1:0] wide_s;
  logic              in_range;
  logic [IDX_W-1:0]  r;
  logic [IDX_W-1:0]  s;
  logic              do_grant;
  logic              do_queue;
  logic              do_handoff;
  logic              do_free;
  resp_t             result;

  assign wide_r   = {{IDX_W{1'b0}}, req_q.requester};
  assign in_range = {1'b0, wide_r} < REQ_LIM;
  assign r        = wide_r[IDX_W-1:0];
  assign s        = succ_id[r];
  assign wide_s   = {{ID_W{1'b0}}, s};

  always_comb begin
    do_grant        = 1'b0;
    do_queue        = 1'b0;
    do_handoff      = 1'b0;
    do_free         = 1'b0;
    result.status   = ST_ERROR;
    result.grant_id = '0;
    if (in_range) begin
      if (req_q.opcode == OP_ACQUIRE) begin
        if ((holder_valid && holder_id == r) || waiting[r]) begin
          result.status = ST_ERROR;
        end else if (!tail_valid) begin
          do_grant        = 1'b1;
          result.status   = ST_GRANTED;
          result.grant_id = req_q.requester;
        end else begin
          do_queue      = 1'b1;
          result.status = ST_QUEUED;
        end
      end else begin
        if (!holder_valid || holder_id != r) begin
          result.status = ST_ERROR;
        end else if (succ_valid[r]) begin
          do_handoff      = 1'b1;
          result.status   = ST_HANDOFF;
          result.grant_id = wide_s[ID_W-1:0];
        end else begin
          do_free       = 1'b1;
          result.status = ST_FREED;
        end
      end
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= in_data;
    end
    if (cmd.commit) begin
      out_data <= result;
    end
    if (cmd.commit && do_queue) begin
      succ_id[tail_id] <= r;
    end
    if (cmd.commit && (do_grant || do_queue)) begin
      tail_id <= r;
    end
    if (cmd.commit && do_grant) begin
      holder_id <= r;
    end else if (cmd.commit && do_handoff) begin
      holder_id <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      holder_valid <= 1'b0;
      tail_valid   <= 1'b0;
      succ_valid   <= '0;
      waiting      <= '0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (do_grant) begin
          holder_valid <= 1'b1;
          tail_valid   <= 1'b1;
        end
        if (do_queue) begin
          succ_valid[tail_id] <= 1'b1;
          waiting[r]          <= 1'b1;
        end
        if (do_handoff) begin
          succ_valid[r] <= 1'b0;
          waiting[s]    <= 1'b0;
        end
        if (do_free) begin
          holder_valid <= 1'b0;
          tail_valid   <= 1'b0;
        end
      end
    end
  end

  // lock held exactly when the queue is non-empty
  a_holder_tail: assert property (@(posedge clk) disable iff (rst)
    holder_valid == tail_valid)
    else $error("holder and tail validity disagree");

  a_holder_not_waiting: assert property (@(posedge clk) disable iff (rst)
    holder_valid |-> !waiting[holder_id])
    else $error("lock holder still marked waiting");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule

FILE: hw/rtl/fifo_queue_lock_manager_unit.sv
// FIFO queue lock manager.
// Input channel (in_valid/in_ready/in_data): one acquire or release item
// carrying a requester id. Output channel (out_valid/out_ready/out_data):
// exactly one result item per input item, in order, with a status code and
// the id that now holds the lock (zero unless granted or handed off).
// The item is captured into req_q at the accepting edge, executed in the
// controller's execute state, and its result is registered on commit.
// The controller alternates capture and execute states, so no new item is
// accepted while one executes; the lock state, links and waiting flags
// update on the commit that ends the execute state.
// The output register lets a new item be accepted while a result waits.
// If the receiver stalls, the next item stays in execute until the output
// register is free, and in_ready stays low meanwhile.
// Reset clears the holder, tail, all link valid bits and waiting flags and
// drops out_valid; the controller resets to idle, where in_ready is high.
module fifo_queue_lock_manager_unit #(
  parameter int REQUESTERS = fqlm_pkg::REQUESTERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fqlm_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fqlm_pkg::resp_t out_data
);
  import fqlm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fqlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fqlm_datapath #(
    .REQUESTERS (REQUESTERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
